// ===== sv/tcpq_pkg.sv =====
// shared types and constants of the three-class priority queue
`timescale 1ns / 1ps

package tcpq_pkg;

    localparam int VAL_W  = 32;
    localparam int CLS_W  = 2;
    localparam int CAP_W  = 7;
    localparam int OCC_W  = 7;
    localparam int NCLASS = 3;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    localparam logic [CLS_W-1:0] CLS_HIGH = 2'd0;
    localparam logic [CLS_W-1:0] CLS_MED  = 2'd1;
    localparam logic [CLS_W-1:0] CLS_LOW  = 2'd2;

    typedef enum logic {
        S_IDLE,
        S_UPD
    } t_state;

    typedef struct packed {
        logic accept;
        logic commit;
    } t_dp_cmd;

endpackage

// ===== sv/tcpq_ctrl.sv =====
// controller: operation sequencing and output word handshake
`timescale 1ns / 1ps

module tcpq_ctrl
    import tcpq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_commit;

    // result may be loaded once the output register is free or being emptied
    assign w_commit = (r_state == S_UPD) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (w_commit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready   = (r_state == S_IDLE);
        o_cmd.accept = (r_state == S_IDLE) && i_in_valid;
        o_cmd.commit = w_commit;
        if (w_commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_accept_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state == S_UPD))
        else $error("accepted word did not enter update");

    a_valid_from_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_UPD))
        else $error("result raised outside update");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD && r_out_valid && !i_out_ready) |=> (r_state == S_UPD))
        else $error("update left while output blocked");

endmodule

// ===== sv/tcpq_dp.sv =====
// datapath: slot memories, class lists, free list, count and result register
`timescale 1ns / 1ps

module tcpq_dp
    import tcpq_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    input  logic                    i_cfg_we,
    input  logic [CAP_W-1:0]        i_cfg_capacity_limit,
    input  logic                    i_kind,
    input  logic signed [VAL_W-1:0] i_item_value,
    input  logic [CLS_W-1:0]        i_priority_class,
    output logic                    o_accepted,
    output logic signed [VAL_W-1:0] o_removed_value,
    output logic [CLS_W-1:0]        o_removed_class,
    output logic [OCC_W-1:0]        o_occupancy,
    output logic                    o_is_empty,
    output logic                    o_is_full
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DepthCnt = CW'(DEPTH);
    localparam logic [AW-1:0] LastSlot = AW'(DEPTH - 1);

    // slot memories
    logic [VAL_W-1:0] r_val_mem  [DEPTH];
    logic [AW-1:0]    r_link_mem [DEPTH];
    logic [VAL_W-1:0] r_val_q;
    logic [AW-1:0]    r_link_q;

    // list state
    logic [AW-1:0]    r_head [NCLASS];
    logic [AW-1:0]    n_head [NCLASS];
    logic [AW-1:0]    r_tail [NCLASS];
    logic [AW-1:0]    n_tail [NCLASS];
    logic [NCLASS-1:0] r_nonempty;
    logic [NCLASS-1:0] n_nonempty;
    logic [AW-1:0]    r_free_head;
    logic [AW-1:0]    n_free_head;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    // slots at or above this mark were never allocated; their link is slot + 1, or 0 for the last slot
    logic [AW:0]      r_fresh;
    logic [AW:0]      n_fresh;
    logic [CAP_W-1:0] r_cap;

    // latched word
    logic             r_kind;
    logic [VAL_W-1:0] r_value;
    logic [CLS_W-1:0] r_cls;
    logic [CLS_W-1:0] r_deq_cls;
    logic             r_deq_any;
    logic [AW-1:0]    r_addr;

    logic [CLS_W-1:0] w_in_cls;
    logic [CLS_W-1:0] w_top_cls;
    logic [AW-1:0]    w_rd_addr;
    logic [AW-1:0]    w_link_rd;
    logic             w_ok;
    logic             w_val_we;
    logic             w_link_we;
    logic [AW-1:0]    w_link_waddr;
    logic [AW-1:0]    w_link_wdata;
    logic [VAL_W-1:0] w_rm_value;
    logic [CLS_W-1:0] w_rm_class;
    logic [CW+CAP_W-1:0] w_cnt_ext;

    function automatic logic at_limit(input logic [CW-1:0] cnt, input logic [CAP_W-1:0] cap);
        logic [CW+CAP_W-1:0] c_ext;
        logic [CW+CAP_W-1:0] l_ext;
        c_ext = {{CAP_W{1'b0}}, cnt};
        l_ext = {{CW{1'b0}}, cap};
        return (c_ext >= l_ext) || (cnt >= DepthCnt);
    endfunction

    // unknown class code folds into low
    assign w_in_cls = (i_priority_class == CLS_HIGH || i_priority_class == CLS_MED)
                      ? i_priority_class : CLS_LOW;

    always_comb begin
        priority if (r_nonempty[CLS_HIGH]) begin
            w_top_cls = CLS_HIGH;
        end else if (r_nonempty[CLS_MED]) begin
            w_top_cls = CLS_MED;
        end else begin
            w_top_cls = CLS_LOW;
        end
    end

    assign w_rd_addr = (i_kind == OP_DEQ) ? r_head[w_top_cls] : r_free_head;

    always_comb begin
        if ({1'b0, r_addr} >= r_fresh) begin
            w_link_rd = (r_addr == LastSlot) ? '0 : r_addr + AW'(1);
        end else begin
            w_link_rd = r_link_q;
        end
    end

    always_comb begin
        n_head       = r_head;
        n_tail       = r_tail;
        n_nonempty   = r_nonempty;
        n_free_head  = r_free_head;
        n_count      = r_count;
        n_fresh      = r_fresh;
        w_ok         = 1'b0;
        w_val_we     = 1'b0;
        w_link_we    = 1'b0;
        w_link_waddr = r_addr;
        w_link_wdata = r_free_head;
        w_rm_value   = '0;
        w_rm_class   = CLS_HIGH;
        if (r_kind == OP_ENQ) begin
            w_ok = (r_count == '0) || !at_limit(r_count, r_cap);
            if (w_ok) begin
                w_val_we    = 1'b1;
                n_free_head = w_link_rd;
                if (r_nonempty[r_cls]) begin
                    w_link_we    = 1'b1;
                    w_link_waddr = r_tail[r_cls];
                    w_link_wdata = r_addr;
                end else begin
                    n_head[r_cls]     = r_addr;
                    n_nonempty[r_cls] = 1'b1;
                end
                n_tail[r_cls] = r_addr;
                n_count       = r_count + CW'(1);
                if ({1'b0, r_addr} == r_fresh) begin
                    n_fresh = r_fresh + (AW + 1)'(1);
                end
            end
        end else begin
            w_ok = r_deq_any;
            if (w_ok) begin
                w_rm_value = r_val_q;
                w_rm_class = r_deq_cls;
                if (r_addr == r_tail[r_deq_cls]) begin
                    n_nonempty[r_deq_cls] = 1'b0;
                end else begin
                    n_head[r_deq_cls] = w_link_rd;
                end
                // freed slot goes on top of the free list
                w_link_we    = 1'b1;
                w_link_waddr = r_addr;
                w_link_wdata = r_free_head;
                n_free_head  = r_addr;
                n_count      = r_count - CW'(1);
            end
        end
    end

    assign w_cnt_ext = {{CAP_W{1'b0}}, n_count};

    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_val_q  <= r_val_mem[w_rd_addr];
            r_link_q <= r_link_mem[w_rd_addr];
        end
        if (i_cmd.commit && w_val_we) begin
            r_val_mem[r_addr] <= r_value;
        end
        if (i_cmd.commit && w_link_we) begin
            r_link_mem[w_link_waddr] <= w_link_wdata;
        end
    end

    // latched word and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind    <= i_kind;
            r_value   <= i_item_value;
            r_cls     <= w_in_cls;
            r_deq_cls <= w_top_cls;
            r_deq_any <= |r_nonempty;
            r_addr    <= w_rd_addr;
        end
        if (i_cmd.commit) begin
            o_accepted      <= w_ok;
            o_removed_value <= w_rm_value;
            o_removed_class <= w_rm_class;
            o_occupancy     <= w_cnt_ext[OCC_W-1:0];
            o_is_empty      <= (n_count == '0);
            o_is_full       <= at_limit(n_count, r_cap);
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NCLASS; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
            end
            r_nonempty  <= '0;
            r_free_head <= '0;
            r_count     <= '0;
            r_fresh     <= '0;
            r_cap       <= CAP_RESET;
        end else begin
            if (i_cmd.commit) begin
                r_head      <= n_head;
                r_tail      <= n_tail;
                r_nonempty  <= n_nonempty;
                r_free_head <= n_free_head;
                r_count     <= n_count;
                r_fresh     <= n_fresh;
            end
            if (i_cfg_we) begin
                r_cap <= i_cfg_capacity_limit;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DepthCnt)
        else $error("entry count above depth");

    a_empty_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) == (r_nonempty == '0))
        else $error("count and class lists disagree on empty");

    a_fresh_cover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (AW + 1)'(r_count) <= r_fresh)
        else $error("more entries than slots ever allocated");

endmodule

// ===== sv/three_class_priority_queue.sv =====
// an accepted word is latched with its slot read; the update loads the result once output is free
// a new word is taken only when idle, after the last one commits, so slot memories stay single-port
// a finished result waits in the output register while the next word is accepted
// reset is synchronous: queue empty, capacity limit back to 64, memories keep their contents
// no clearing pass; never-allocated slots are tracked by a fresh-slot mark
`timescale 1ns / 1ps

module three_class_priority_queue
    import tcpq_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_kind,
    input  logic signed [VAL_W-1:0] i_item_value,
    input  logic [CLS_W-1:0]        i_priority_class,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic                    o_accepted,
    output logic signed [VAL_W-1:0] o_removed_value,
    output logic [CLS_W-1:0]        o_removed_class,
    output logic [OCC_W-1:0]        o_occupancy,
    output logic                    o_is_empty,
    output logic                    o_is_full,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CAP_W-1:0]        i_cfg_capacity_limit
);

    t_dp_cmd w_cmd;

    assign o_cfg_ready = 1'b1;

    tcpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    tcpq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (w_cmd),
        .i_cfg_we             (i_cfg_valid && o_cfg_ready),
        .i_cfg_capacity_limit (i_cfg_capacity_limit),
        .i_kind               (i_kind),
        .i_item_value         (i_item_value),
        .i_priority_class     (i_priority_class),
        .o_accepted           (o_accepted),
        .o_removed_value      (o_removed_value),
        .o_removed_class      (o_removed_class),
        .o_occupancy          (o_occupancy),
        .o_is_empty           (o_is_empty),
        .o_is_full            (o_is_full)
    );

endmodule
